### rtl/met_pkg.sv
// ============================================================================
// met_pkg - shared types and helpers for the Mandelbrot escape-time core
// Register map indexes, fixed word widths and the saturation helper.
// ============================================================================
package met_pkg;

    // Fixed-point word and intermediate widths
    localparam int WORD_W = 32;
    localparam int SQ_W   = 64;    // exact 32x32 product
    localparam int PROD_W = 66;    // 33x33 shared multiplier output
    localparam int SUM_W  = 68;    // headroom for add/sub before saturation
    localparam int CNT_W  = 16;
    localparam int ADDR_W = 5;
    localparam int RIDX_W = 3;

    // Configuration register indexes (byte address = 4 * index)
    typedef enum logic [RIDX_W-1:0] {
        REG_ORIGIN_RE = 3'd0,
        REG_ORIGIN_IM = 3'd1,
        REG_PIXEL_STEP = 3'd2,
        REG_MAX_ITER  = 3'd3,
        REG_SHADE_SCALE = 3'd4
    } reg_idx_t;

    // Reset values of the configuration registers
    localparam logic signed [WORD_W-1:0] ORIGIN_RE_RST  = -32'sd140928614;
    localparam logic signed [WORD_W-1:0] ORIGIN_IM_RST  = -32'sd80530637;
    localparam logic [WORD_W-2:0]        PIXEL_STEP_RST = 31'd671089;
    localparam logic [CNT_W-1:0]         MAX_ITER_RST   = 16'd10;
    localparam logic [WORD_W-1:0]        SHADE_SCALE_RST = 32'd10;

    // Clamp a wide signed value to the 32-bit signed range
    function automatic logic signed [WORD_W-1:0] sat_word(input logic signed [SUM_W-1:0] v);
        logic signed [SUM_W-1:0] hi;
        logic signed [SUM_W-1:0] lo;
        hi = SUM_W'(signed'(32'sh7FFF_FFFF));
        lo = SUM_W'(signed'(32'sh8000_0000));
        if (v > hi)
        begin
            return 32'sh7FFF_FFFF;
        end
        else if (v < lo)
        begin
            return 32'sh8000_0000;
        end
        return v[WORD_W-1:0];
    endfunction

endpackage

### rtl/mandelbrot_escape_time_core.sv
// ============================================================================
// mandelbrot_escape_time_core - escape-time iteration for one pixel per item
// Maps a pixel to c = origin + pixel * step (signed fixed point), iterates
// z = z*z + c on one shared multiplier, and divides out a shade value.
// ============================================================================
//
// Usage:
//  - Input stream (s_axis_*): one item per pixel, tdata = {pixel_y, pixel_x}.
//  - Output stream (m_axis_*): one item per pixel, tdata = {shade, count},
//    tuser = in_set flag.
//  - APB port: origin_re, origin_im, pixel_step, max_iterations, shade_scale
//    at byte addresses 0, 4, 8, 12, 16. Write only while the core is idle.
//  - Steps per item: form c (ST_MUL_CR, ST_MUL_CI, ST_ADD_CI), iterate
//    (ST_UPDATE, ST_SQ_R, ST_SQ_I, ST_CHECK), then the shade product and
//    bit-serial divide (ST_SHADE_MUL, ST_DIV_LOAD, ST_DIVIDE, ST_FINISH).
//    The core returns to idle before it accepts the next pixel. The
//    iteration loop is bound by the single 33x33 multiplier
//    (three products per iteration plus one update step); the shade divide
//    retires one quotient bit per cycle.
//  - One pixel is in flight at a time; s_axis_tready is high only when the
//    sequencer is idle. A finished result sits in the output register, so
//    the next pixel is taken while it waits; a stalled receiver only holds
//    the sequencer at the end of the following pixel.
//  - Reset (rst_n low, asynchronous) empties the output register, returns
//    the sequencer to idle and loads the register defaults.
//
module mandelbrot_escape_time_core #(
    parameter int COORD_BITS = 10,
    parameter int FRAC_BITS  = 26
) (
    input  logic                                   clk,
    input  logic                                   rst_n,
    // Pixel input: [COORD_BITS-1:0] pixel_x, [2*COORD_BITS-1:COORD_BITS] pixel_y
    input  logic                                   s_axis_tvalid,
    output logic                                   s_axis_tready,
    input  logic [((2*COORD_BITS+7)/8)*8-1:0]      s_axis_tdata,
    // Result: [15:0] iteration_count, [47:16] shade
    output logic                                   m_axis_tvalid,
    input  logic                                   m_axis_tready,
    output logic [47:0]                            m_axis_tdata,
    // Result flag: [0] in_set
    output logic                                   m_axis_tuser,
    // Configuration
    input  logic                                   psel,
    input  logic                                   penable,
    input  logic                                   pwrite,
    input  logic [met_pkg::ADDR_W-1:0]             paddr,
    input  logic [31:0]                            pwdata,
    output logic [31:0]                            prdata,
    output logic                                   pready
);
    import met_pkg::*;

    localparam int ESC_BIT = 2 * FRAC_BITS + 2;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_MUL_CR,
        ST_MUL_CI,
        ST_ADD_CI,
        ST_UPDATE,
        ST_SQ_R,
        ST_SQ_I,
        ST_CHECK,
        ST_SHADE_MUL,
        ST_DIV_LOAD,
        ST_DIVIDE,
        ST_FINISH
    } state_t;

    // Control state
    state_t                     state_reg, state_next;
    logic                       out_valid_reg, out_valid_next;
    logic [4:0]                 div_cnt_reg, div_cnt_next;

    // Configuration registers
    logic signed [WORD_W-1:0]   origin_re_reg, origin_re_next;
    logic signed [WORD_W-1:0]   origin_im_reg, origin_im_next;
    logic [WORD_W-2:0]          pixel_step_reg, pixel_step_next;
    logic [CNT_W-1:0]           max_iter_reg, max_iter_next;
    logic [WORD_W-1:0]          shade_scale_reg, shade_scale_next;

    // Datapath registers
    logic [COORD_BITS-1:0]      px_reg, px_next;
    logic [COORD_BITS-1:0]      py_reg, py_next;
    logic [CNT_W-1:0]           limit_reg, limit_next;
    logic [CNT_W-1:0]           count_reg, count_next;
    logic signed [WORD_W-1:0]   cr_reg, cr_next;
    logic signed [WORD_W-1:0]   ci_reg, ci_next;
    logic signed [WORD_W-1:0]   zr_reg, zr_next;
    logic signed [WORD_W-1:0]   zi_reg, zi_next;
    logic signed [SQ_W-1:0]     sq_r_reg, sq_r_next;
    logic signed [SQ_W-1:0]     sq_i_reg, sq_i_next;
    logic signed [PROD_W-1:0]   prod_reg;
    logic [CNT_W-1:0]           rem_reg, rem_next;
    logic [WORD_W-1:0]          quo_reg, quo_next;
    logic [CNT_W-1:0]           out_count_reg, out_count_next;
    logic                       out_in_set_reg, out_in_set_next;
    logic [WORD_W-1:0]          out_shade_reg, out_shade_next;

    // Shared multiplier operands
    logic signed [WORD_W:0]     mul_a;
    logic signed [WORD_W:0]     mul_b;

    // Helpers
    logic                       cfg_wr;
    logic [RIDX_W-1:0]          cfg_idx;
    logic [SQ_W-1:0]            mag;
    logic                       escape;
    logic signed [SUM_W-1:0]    rr_ext;
    logic signed [SUM_W-1:0]    ii_ext;
    logic signed [SUM_W-1:0]    ri_ext;
    logic [CNT_W:0]             trial;
    logic                       q_bit;

    assign cfg_wr  = psel & penable & pwrite & pready;
    assign cfg_idx = paddr[ADDR_W-1:2];
    assign pready  = 1'b1;

    // Register readback
    always_comb
    begin
        unique case (cfg_idx)
            REG_ORIGIN_RE:   prdata = origin_re_reg;
            REG_ORIGIN_IM:   prdata = origin_im_reg;
            REG_PIXEL_STEP:  prdata = {1'b0, pixel_step_reg};
            REG_MAX_ITER:    prdata = {16'd0, max_iter_reg};
            REG_SHADE_SCALE: prdata = shade_scale_reg;
            default:         prdata = '0;
        endcase
    end

    // Configuration writes
    always_comb
    begin
        origin_re_next   = origin_re_reg;
        origin_im_next   = origin_im_reg;
        pixel_step_next  = pixel_step_reg;
        max_iter_next    = max_iter_reg;
        shade_scale_next = shade_scale_reg;
        if (cfg_wr)
        begin
            unique case (cfg_idx)
                REG_ORIGIN_RE:   origin_re_next   = pwdata;
                REG_ORIGIN_IM:   origin_im_next   = pwdata;
                REG_PIXEL_STEP:  pixel_step_next  = pwdata[WORD_W-2:0];
                REG_MAX_ITER:    max_iter_next    = pwdata[CNT_W-1:0];
                REG_SHADE_SCALE: shade_scale_next = pwdata;
                default:         ;
            endcase
        end
    end

    // Shared multiplier operand select
    always_comb
    begin
        unique case (state_reg)
            ST_MUL_CR:
            begin
                mul_a = $signed((WORD_W+1)'(px_reg));
                mul_b = $signed((WORD_W+1)'(pixel_step_reg));
            end
            ST_MUL_CI:
            begin
                mul_a = $signed((WORD_W+1)'(py_reg));
                mul_b = $signed((WORD_W+1)'(pixel_step_reg));
            end
            ST_SQ_R:
            begin
                mul_a = (WORD_W+1)'(zr_reg);
                mul_b = (WORD_W+1)'(zr_reg);
            end
            ST_SQ_I:
            begin
                mul_a = (WORD_W+1)'(zi_reg);
                mul_b = (WORD_W+1)'(zi_reg);
            end
            ST_SHADE_MUL:
            begin
                mul_a = $signed((WORD_W+1)'(count_reg));
                mul_b = $signed((WORD_W+1)'(shade_scale_reg));
            end
            default:
            begin
                // cross term zr*zi for the next update
                mul_a = (WORD_W+1)'(zr_reg);
                mul_b = (WORD_W+1)'(zi_reg);
            end
        endcase
    end

    // Floor-shifted products for the update step
    assign rr_ext = SUM_W'(sq_r_reg >>> FRAC_BITS);
    assign ii_ext = SUM_W'(sq_i_reg >>> FRAC_BITS);
    assign ri_ext = SUM_W'(prod_reg >>> (FRAC_BITS - 1));

    // Escape test on the exact |z|^2
    assign mag = $unsigned(sq_r_reg) + $unsigned(prod_reg[SQ_W-1:0]);
    generate
        if (ESC_BIT < SQ_W)
        begin : g_esc
            assign escape = |mag[SQ_W-1:ESC_BIT];
        end
        else
        begin : g_no_esc
            assign escape = 1'b0;
        end
    endgenerate

    // Restoring divide step: one quotient bit per cycle
    assign trial = {rem_reg, quo_reg[WORD_W-1]};
    assign q_bit = (trial >= {1'b0, limit_reg});

    // Sequencer
    always_comb
    begin
        state_next      = state_reg;
        out_valid_next  = out_valid_reg;
        div_cnt_next    = div_cnt_reg;
        px_next         = px_reg;
        py_next         = py_reg;
        limit_next      = limit_reg;
        count_next      = count_reg;
        cr_next         = cr_reg;
        ci_next         = ci_reg;
        zr_next         = zr_reg;
        zi_next         = zi_reg;
        sq_r_next       = sq_r_reg;
        sq_i_next       = sq_i_reg;
        rem_next        = rem_reg;
        quo_next        = quo_reg;
        out_count_next  = out_count_reg;
        out_in_set_next = out_in_set_reg;
        out_shade_next  = out_shade_reg;

        if (out_valid_reg && m_axis_tready)
        begin
            out_valid_next = 1'b0;
        end

        unique case (state_reg)
            ST_IDLE:
            begin
                if (s_axis_tvalid)
                begin
                    px_next    = s_axis_tdata[COORD_BITS-1:0];
                    py_next    = s_axis_tdata[2*COORD_BITS-1:COORD_BITS];
                    limit_next = (max_iter_reg == '0) ? CNT_W'(1) : max_iter_reg;
                    count_next = '0;
                    zr_next    = '0;
                    zi_next    = '0;
                    sq_r_next  = '0;
                    sq_i_next  = '0;
                    state_next = ST_MUL_CR;
                end
            end
            ST_MUL_CR:
            begin
                state_next = ST_MUL_CI;
            end
            ST_MUL_CI:
            begin
                cr_next    = sat_word(SUM_W'(origin_re_reg) + SUM_W'(prod_reg));
                state_next = ST_ADD_CI;
            end
            ST_ADD_CI:
            begin
                ci_next    = sat_word(SUM_W'(origin_im_reg) + SUM_W'(prod_reg));
                state_next = ST_UPDATE;
            end
            // z = z*z + c from the held squares and the cross term
            ST_UPDATE:
            begin
                zr_next    = sat_word(rr_ext - ii_ext + SUM_W'(cr_reg));
                zi_next    = sat_word(ri_ext + SUM_W'(ci_reg));
                count_next = count_reg + CNT_W'(1);
                state_next = ST_SQ_R;
            end
            ST_SQ_R:
            begin
                state_next = ST_SQ_I;
            end
            ST_SQ_I:
            begin
                sq_r_next  = prod_reg[SQ_W-1:0];
                state_next = ST_CHECK;
            end
            ST_CHECK:
            begin
                sq_i_next = prod_reg[SQ_W-1:0];
                if (escape || (count_reg == limit_reg))
                begin
                    state_next = ST_SHADE_MUL;
                end
                else
                begin
                    state_next = ST_UPDATE;
                end
            end
            ST_SHADE_MUL:
            begin
                state_next = ST_DIV_LOAD;
            end
            // quotient fits 32 bits since count <= limit
            ST_DIV_LOAD:
            begin
                rem_next     = prod_reg[47:32];
                quo_next     = prod_reg[31:0];
                div_cnt_next = '0;
                state_next   = ST_DIVIDE;
            end
            ST_DIVIDE:
            begin
                rem_next     = q_bit ? CNT_W'(trial - {1'b0, limit_reg}) : trial[CNT_W-1:0];
                quo_next     = {quo_reg[WORD_W-2:0], q_bit};
                div_cnt_next = div_cnt_reg + 5'd1;
                if (div_cnt_reg == 5'd31)
                begin
                    state_next = ST_FINISH;
                end
            end
            ST_FINISH:
            begin
                if (!out_valid_reg || m_axis_tready)
                begin
                    out_valid_next  = 1'b1;
                    out_count_next  = count_reg;
                    out_in_set_next = (count_reg == limit_reg);
                    out_shade_next  = quo_reg;
                    state_next      = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // Control and configuration registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg       <= ST_IDLE;
            out_valid_reg   <= 1'b0;
            div_cnt_reg     <= '0;
            origin_re_reg   <= ORIGIN_RE_RST;
            origin_im_reg   <= ORIGIN_IM_RST;
            pixel_step_reg  <= PIXEL_STEP_RST;
            max_iter_reg    <= MAX_ITER_RST;
            shade_scale_reg <= SHADE_SCALE_RST;
        end
        else
        begin
            state_reg       <= state_next;
            out_valid_reg   <= out_valid_next;
            div_cnt_reg     <= div_cnt_next;
            origin_re_reg   <= origin_re_next;
            origin_im_reg   <= origin_im_next;
            pixel_step_reg  <= pixel_step_next;
            max_iter_reg    <= max_iter_next;
            shade_scale_reg <= shade_scale_next;
        end
    end

    // Payload registers and the shared multiplier output
    always_ff @(posedge clk)
    begin
        prod_reg       <= mul_a * mul_b;
        px_reg         <= px_next;
        py_reg         <= py_next;
        limit_reg      <= limit_next;
        count_reg      <= count_next;
        cr_reg         <= cr_next;
        ci_reg         <= ci_next;
        zr_reg         <= zr_next;
        zi_reg         <= zi_next;
        sq_r_reg       <= sq_r_next;
        sq_i_reg       <= sq_i_next;
        rem_reg        <= rem_next;
        quo_reg        <= quo_next;
        out_count_reg  <= out_count_next;
        out_in_set_reg <= out_in_set_next;
        out_shade_reg  <= out_shade_next;
    end

    // Ports
    assign s_axis_tready = (state_reg == ST_IDLE);
    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata  = {out_shade_reg, out_count_reg};
    assign m_axis_tuser  = out_in_set_reg;

endmodule
